// ----- rtl/clpm_pkg.sv -----
// ----------------------------------------------------------------------------
// clpm_pkg
// Shared types and constants for the CPU load percent monitor.
// ----------------------------------------------------------------------------
package clpm_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int CPU_AW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CPU_IDX_W  = 3;
  localparam int TIME_W     = 64;
  localparam int DELTA_W    = 32;
  localparam int LOAD_W     = 7;
  localparam int SUM_W      = 10;
  localparam int CNT_W      = 4;
  localparam int DVD_W      = 39;
  localparam int DVS_W      = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;
  localparam logic [SUM_W-1:0]  SUM_MAX    = 10'd1023;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_IOWAIT_BUSY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NICE_AS_IDLE      = 2'd1;

  typedef struct packed {
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] iowait;
    logic [TIME_W-1:0] nice;
  } hist_ent_t;

  typedef struct packed {
    logic we_main;
    logic we_nice;
  } hist_wr_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [LOAD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/clpm_hist.sv -----
// ----------------------------------------------------------------------------
// clpm_hist
// Per-CPU store of the previous cumulative counters.
// ----------------------------------------------------------------------------
module clpm_hist
  import clpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CPU_AW-1:0] addr_i,
  input  hist_wr_t          wr_i,
  input  hist_ent_t         wdata_i,
  output hist_ent_t         rdata_o
);

  hist_ent_t mem_q [NUM_CPUS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        mem_q[i] <= '0;
      end
    end else begin
      if (wr_i.we_main) begin
        mem_q[addr_i].wall   <= wdata_i.wall;
        mem_q[addr_i].idle   <= wdata_i.idle;
        mem_q[addr_i].iowait <= wdata_i.iowait;
      end
      if (wr_i.we_nice) begin
        mem_q[addr_i].nice <= wdata_i.nice;
      end
    end
  end

  assign rdata_o = mem_q[addr_i];

endmodule

// ----- rtl/clpm_div.sv -----
// ----------------------------------------------------------------------------
// clpm_div
// Shared restoring divider, one quotient bit per cycle, 7-bit quotient.
// Requires dividend < 128 * divisor.
// ----------------------------------------------------------------------------
module clpm_div
  import clpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int DIV_CW = $clog2(LOAD_W);
  localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(LOAD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [LOAD_W-1:0] low_q, low_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [LOAD_W-1:0] quo_q, quo_d;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  assign trial = {rem_q, low_q[LOAD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[DVD_W-1:LOAD_W];
      low_d  = req_i.dividend[LOAD_W-1:0];
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      low_d = {low_q[LOAD_W-2:0], 1'b0};
      quo_d = {quo_q[LOAD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/cpu_load_percent_monitor.sv -----
// ----------------------------------------------------------------------------
// cpu_load_percent_monitor
// Per-CPU busy percentage from cumulative idle time, with round average.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                  Beat
// in       in   in_valid_i / in_ready_o    cpu_index, wall/idle/iowait/nice, last
// out      out  out_valid_o / out_ready_i  cpu_load, average_load, average_valid
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An input beat runs through the delta, nice, iowait, compare, multiply and
// load divide states to its result; the last beat of a round also runs the
// 7-step shared divider once more, for the round average.
// One beat is in flight at a time; in_ready_o drops from accept until the
// result beat is taken. Config writes are accepted in every cycle.
// Reset clears the per-CPU history and the round accumulator, and sets the config to iowait idle, nice idle.
// ----------------------------------------------------------------------------
module cpu_load_percent_monitor
  import clpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CPU_IDX_W-1:0] cpu_index_i,
  input  logic [TIME_W-1:0]    wall_us_i,
  input  logic [TIME_W-1:0]    idle_us_i,
  input  logic [TIME_W-1:0]    iowait_us_i,
  input  logic [TIME_W-1:0]    nice_us_i,
  input  logic                 last_in_round_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LOAD_W-1:0]    cpu_load_o,
  output logic [LOAD_W-1:0]    average_load_o,
  output logic                 average_valid_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DELTA = 12'b0000_0000_0010,
    S_NICE  = 12'b0000_0000_0100,
    S_IOW   = 12'b0000_0000_1000,
    S_CMP   = 12'b0000_0001_0000,
    S_MUL   = 12'b0000_0010_0000,
    S_LDIV  = 12'b0000_0100_0000,
    S_LWAIT = 12'b0000_1000_0000,
    S_ACC   = 12'b0001_0000_0000,
    S_ADIV  = 12'b0010_0000_0000,
    S_AWAIT = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic cib_q, nai_q;

  hist_ent_t            in_q;
  logic [CPU_IDX_W-1:0] cpu_q;
  logic                 last_q;
  logic                 in_range_q;

  logic [DELTA_W-1:0] dwall_q, didle_q, diow_q, dnice_q;
  logic [DELTA_W-1:0] diff_q;
  logic               zero_q;
  logic [DVD_W-1:0]   prod_q;

  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LOAD_W-1:0] load_q, avg_q;

  logic                 in_acc;
  logic [CPU_AW+2:0]    idx_ext;
  logic [CPU_AW-1:0]    hist_addr;
  hist_wr_t             hist_wr;
  hist_ent_t            hist_rd;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [LOAD_W-1:0]    load_now;
  logic [SUM_W:0]       sum_wide;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  assign idx_ext   = {{CPU_AW{1'b0}}, cpu_q};
  assign hist_addr = idx_ext[CPU_AW-1:0];

  assign hist_wr.we_main = (state_q == S_DELTA) && in_range_q;
  assign hist_wr.we_nice = (state_q == S_DELTA) && in_range_q && nai_q;

  clpm_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (hist_addr),
    .wr_i    (hist_wr),
    .wdata_i (in_q),
    .rdata_o (hist_rd)
  );

  always_comb begin
    div_req.start    = (state_q == S_LDIV) || (state_q == S_ADIV);
    div_req.dividend = zero_q ? '0 : prod_q;
    div_req.divisor  = zero_q ? DVS_W'(1) : dwall_q;
    if (state_q == S_ADIV) begin
      div_req.dividend = DVD_W'(sum_q);
      div_req.divisor  = DVS_W'(cnt_q);
    end
  end

  clpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign load_now = zero_q ? '0 : div_rsp.quotient;
  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(load_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_DELTA;
      S_DELTA: state_d = S_NICE;
      S_NICE:  state_d = S_IOW;
      S_IOW:   state_d = S_CMP;
      S_CMP:   state_d = S_MUL;
      S_MUL:   state_d = S_LDIV;
      S_LDIV:  state_d = S_LWAIT;
      S_LWAIT: if (div_rsp.done) state_d = S_ACC;
      S_ACC:   state_d = last_q ? S_ADIV : S_OUT;
      S_ADIV:  state_d = S_AWAIT;
      S_AWAIT: if (div_rsp.done) state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cib_q   <= 1'b0;
      nai_q   <= 1'b1;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_COUNT_IOWAIT_BUSY: cib_q <= cfg_data_i;
          REG_NICE_AS_IDLE:      nai_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_ACC) begin
        sum_q <= (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        if (cnt_q < COUNT_MAX) cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == S_AWAIT) && div_rsp.done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.wall   <= wall_us_i;
      in_q.idle   <= idle_us_i;
      in_q.iowait <= iowait_us_i;
      in_q.nice   <= nice_us_i;
      cpu_q       <= cpu_index_i;
      last_q      <= last_in_round_i;
      in_range_q  <= {{(32-CPU_IDX_W){1'b0}}, cpu_index_i} < 32'(NUM_CPUS);
    end
    case (state_q)
      S_DELTA: begin
        dwall_q <= in_q.wall[DELTA_W-1:0] - hist_rd.wall[DELTA_W-1:0];
        didle_q <= in_q.idle[DELTA_W-1:0] - hist_rd.idle[DELTA_W-1:0];
        diow_q  <= in_q.iowait[DELTA_W-1:0] - hist_rd.iowait[DELTA_W-1:0];
        dnice_q <= in_q.nice[DELTA_W-1:0] - hist_rd.nice[DELTA_W-1:0];
      end
      S_NICE: if (nai_q) didle_q <= didle_q + dnice_q;
      S_IOW:  if (cib_q && (didle_q >= diow_q)) didle_q <= didle_q - diow_q;
      S_CMP: begin
        zero_q <= !in_range_q || (dwall_q == '0) || (dwall_q < didle_q);
        diff_q <= dwall_q - didle_q;
      end
      S_MUL:   prod_q <= DVD_W'(diff_q) * DVD_W'(LOAD_SCALE);
      S_LWAIT: if (div_rsp.done) load_q <= load_now;
      S_ACC:   avg_q <= '0;
      S_AWAIT: if (div_rsp.done) avg_q <= div_rsp.quotient;
      default: ;
    endcase
  end

  assign cpu_load_o      = load_q;
  assign average_load_o  = avg_q;
  assign average_valid_o = last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output both open");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cpu_load_o <= LOAD_SCALE) && (average_load_o <= LOAD_SCALE))
    else $error("load above 100");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !average_valid_o) |-> (average_load_o == '0))
    else $error("average shown outside round end");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_round_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_AWAIT) && div_rsp.done) |=> (sum_q == '0) && (cnt_q == '0))
    else $error("accumulator not cleared at round end");

endmodule

// ----- tb/cpu_load_percent_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// cpu_load_percent_monitor_checker
// Watches the input, result and register channels of the load monitor. For
// every accepted input beat it predicts the CPU load and the round average,
// then compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpu_load_percent_monitor_checker
  import clpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [CPU_IDX_W-1:0] cpu_index_i,
  input  logic [TIME_W-1:0]    wall_us_i,
  input  logic [TIME_W-1:0]    idle_us_i,
  input  logic [TIME_W-1:0]    iowait_us_i,
  input  logic [TIME_W-1:0]    nice_us_i,
  input  logic                 last_in_round_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [LOAD_W-1:0]    cpu_load_i,
  input  logic [LOAD_W-1:0]    average_load_i,
  input  logic                 average_valid_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_count_o
);

  typedef struct packed {
    logic [LOAD_W-1:0] cpu_load;
    logic [LOAD_W-1:0] average_load;
    logic              average_valid;
  } load_result_t;

  logic [TIME_W-1:0] seen_wall   [NUM_CPUS];
  logic [TIME_W-1:0] seen_idle   [NUM_CPUS];
  logic [TIME_W-1:0] seen_iowait [NUM_CPUS];
  logic [TIME_W-1:0] seen_nice   [NUM_CPUS];
  int unsigned       round_sum;
  int unsigned       round_items;
  logic              iowait_busy;
  logic              nice_idle;
  load_result_t      expected_loads_q[$];

  function automatic logic [LOAD_W-1:0] busy_percent(logic [DELTA_W-1:0] d_wall,
                                                     logic [DELTA_W-1:0] d_idle);
    logic [63:0] scaled;
    if (d_wall == '0 || d_wall < d_idle) return '0;
    scaled = 64'(d_wall - d_idle) * 64'(LOAD_SCALE);
    return LOAD_W'(scaled / 64'(d_wall));
  endfunction

  task automatic predict_sample();
    logic [DELTA_W-1:0] d_wall;
    logic [DELTA_W-1:0] d_idle;
    logic [DELTA_W-1:0] d_iowait;
    logic [DELTA_W-1:0] d_nice;
    logic [CPU_AW-1:0]  cpu;
    logic [LOAD_W-1:0]  load;
    load_result_t       res;
    cpu  = CPU_AW'(cpu_index_i);
    load = '0;
    if (32'(cpu_index_i) < NUM_CPUS) begin
      d_wall   = DELTA_W'(wall_us_i - seen_wall[cpu]);
      d_idle   = DELTA_W'(idle_us_i - seen_idle[cpu]);
      d_iowait = DELTA_W'(iowait_us_i - seen_iowait[cpu]);
      seen_wall[cpu]   = wall_us_i;
      seen_idle[cpu]   = idle_us_i;
      seen_iowait[cpu] = iowait_us_i;
      if (nice_idle) begin
        d_nice         = DELTA_W'(nice_us_i - seen_nice[cpu]);
        seen_nice[cpu] = nice_us_i;
        d_idle         = d_idle + d_nice;
      end
      if (iowait_busy && d_idle >= d_iowait) d_idle = d_idle - d_iowait;
      load = busy_percent(d_wall, d_idle);
    end
    round_sum = round_sum + load;
    if (round_sum > SUM_MAX) round_sum = SUM_MAX;
    if (round_items < COUNT_MAX) round_items++;
    res.cpu_load      = load;
    res.average_load  = '0;
    res.average_valid = 1'b0;
    if (last_in_round_i) begin
      res.average_load  = LOAD_W'(round_sum / round_items);
      res.average_valid = 1'b1;
      round_sum         = 0;
      round_items       = 0;
    end
    expected_loads_q.push_back(res);
  endtask

  task automatic check_result();
    load_result_t exp_res;
    if (expected_loads_q.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("result beat with nothing pending: load %0d avg %0d avg_valid %0d",
                 cpu_load_i, average_load_i, average_valid_i);
      return;
    end
    exp_res = expected_loads_q.pop_front();
    if (exp_res.cpu_load != cpu_load_i || exp_res.average_load != average_load_i ||
        exp_res.average_valid != average_valid_i) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("mismatch: load exp %0d got %0d, avg exp %0d got %0d, avg_valid exp %0d got %0d",
                 exp_res.cpu_load, cpu_load_i, exp_res.average_load, average_load_i,
                 exp_res.average_valid, average_valid_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seen_wall   = '{default: '0};
      seen_idle   = '{default: '0};
      seen_iowait = '{default: '0};
      seen_nice   = '{default: '0};
      round_sum   = 0;
      round_items = 0;
      iowait_busy = 1'b0;
      nice_idle   = 1'b1;
      expected_loads_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_COUNT_IOWAIT_BUSY: iowait_busy = cfg_data_i;
          REG_NICE_AS_IDLE:      nice_idle   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_sample();
    end
    pending_count_o = expected_loads_q.size();
  end

endmodule

// ----- tb/cpu_load_percent_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_load_percent_monitor_tb
// Drives per-CPU cumulative time samples into the load monitor: a directed
// set of corner cases, then random sample streams under every register
// setting, with random idling on both channels and long back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpu_load_percent_monitor_tb;
  import clpm_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CPU_IDX_W-1:0] cpu_index_i;
  logic [TIME_W-1:0]    wall_us_i;
  logic [TIME_W-1:0]    idle_us_i;
  logic [TIME_W-1:0]    iowait_us_i;
  logic [TIME_W-1:0]    nice_us_i;
  logic                 last_in_round_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LOAD_W-1:0]    cpu_load_o;
  logic [LOAD_W-1:0]    average_load_o;
  logic                 average_valid_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic                 cfg_data_i;

  int                   mismatch_count;
  int                   pending_count;
  logic                 gaps_on;
  logic                 rx_long_hold;
  logic                 rx_hold_done;
  int unsigned          round_left;
  logic [CPU_IDX_W-1:0] long_cpu;
  logic [TIME_W-1:0]    cum_wall   [NUM_CPUS];
  logic [TIME_W-1:0]    cum_idle   [NUM_CPUS];
  logic [TIME_W-1:0]    cum_iowait [NUM_CPUS];
  logic [TIME_W-1:0]    cum_nice   [NUM_CPUS];

  cpu_load_percent_monitor u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .cpu_index_i, .wall_us_i, .idle_us_i, .iowait_us_i, .nice_us_i, .last_in_round_i,
    .out_valid_o, .out_ready_i,
    .cpu_load_o, .average_load_o, .average_valid_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  cpu_load_percent_monitor_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .cpu_index_i, .wall_us_i, .idle_us_i, .iowait_us_i, .nice_us_i, .last_in_round_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .cpu_load_i(cpu_load_o), .average_load_i(average_load_o),
    .average_valid_i(average_valid_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: short random stalls, one long hold on request
  initial begin
    out_ready_i  = 1'b1;
    rx_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_long_hold && !rx_hold_done) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        out_ready_i  = 1'b1;
        rx_hold_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [CPU_IDX_W-1:0] cpu, input logic [TIME_W-1:0] w,
                             input logic [TIME_W-1:0] i, input logic [TIME_W-1:0] io,
                             input logic [TIME_W-1:0] n, input logic last);
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    cpu_index_i     = cpu;
    wall_us_i       = w;
    idle_us_i       = i;
    iowait_us_i     = io;
    nice_us_i       = n;
    last_in_round_i = last;
    cum_wall[cpu]   = w;
    cum_idle[cpu]   = i;
    cum_iowait[cpu] = io;
    cum_nice[cpu]   = n;
    do @(posedge clk_i); while (!in_ready_o);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_count == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input logic iowait_busy, input logic nice_idle);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_COUNT_IOWAIT_BUSY, iowait_busy);
      write_reg(REG_NICE_AS_IDLE, nice_idle);
    end else begin
      write_reg(REG_NICE_AS_IDLE, nice_idle);
      write_reg(REG_COUNT_IOWAIT_BUSY, iowait_busy);
    end
  endtask

  // mostly consistent counter streams per CPU, some jumps, noise and repeats
  task automatic send_random();
    logic [CPU_IDX_W-1:0] cpu;
    logic [TIME_W-1:0]    d_wall;
    logic [TIME_W-1:0]    d_idle;
    logic [TIME_W-1:0]    d_iowait;
    logic [TIME_W-1:0]    d_nice;
    int unsigned          mode;
    logic                 last;
    if (round_left == 0)
      round_left = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 30) : $urandom_range(1, 8);
    last = (round_left == 1);
    round_left--;
    cpu  = CPU_IDX_W'($urandom_range(0, 7));
    mode = $urandom_range(0, 19);
    if (mode < 14) begin
      d_wall = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 200000));
      d_idle = (d_wall == 0) ? '0 : 64'($urandom_range(0, 32'(d_wall)));
      if ($urandom_range(0, 15) == 0) d_idle = d_wall + $urandom_range(1, 50);
      d_iowait = 64'($urandom_range(0, 32'(d_idle)));
      if ($urandom_range(0, 7) == 0) d_iowait = d_idle + $urandom_range(1, 1000);
      d_nice = $urandom_range(0, 1) ? '0 : 64'($urandom_range(0, 32'(d_wall >> 2)));
      send_sample(cpu, cum_wall[cpu] + d_wall, cum_idle[cpu] + d_idle,
                  cum_iowait[cpu] + d_iowait, cum_nice[cpu] + d_nice, last);
    end else if (mode < 16) begin
      send_sample(cpu, cum_wall[cpu] + {$urandom, $urandom},
                  cum_idle[cpu] + {$urandom, $urandom},
                  cum_iowait[cpu] + {$urandom, $urandom},
                  cum_nice[cpu] + {$urandom, $urandom}, last);
    end else if (mode < 18) begin
      send_sample(cpu, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, last);
    end else begin
      send_sample(cpu, cum_wall[cpu], cum_idle[cpu], cum_iowait[cpu], cum_nice[cpu], last);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cpu_index_i     = '0;
    wall_us_i       = '0;
    idle_us_i       = '0;
    iowait_us_i     = '0;
    nice_us_i       = '0;
    last_in_round_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_COUNT_IOWAIT_BUSY;
    cfg_data_i      = 1'b0;
    gaps_on         = 1'b1;
    rx_long_hold    = 1'b0;
    round_left      = 0;
    long_cpu        = '0;
    cum_wall        = '{default: '0};
    cum_idle        = '{default: '0};
    cum_iowait      = '{default: '0};
    cum_nice        = '{default: '0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: iowait idle, nice idle
    send_sample(3'd0, '0, '0, '0, '0, 1'b1);                            // zero wall, round of one
    send_sample(3'd1, 64'd1000, '0, '0, '0, 1'b0);                      // fully busy
    send_sample(3'd1, 64'd2000, 64'd500, '0, 64'd250, 1'b0);            // nice folded into idle
    send_sample(3'd2, 64'd500, 64'd500, '0, '0, 1'b0);                  // idle equals wall
    send_sample(3'd3, 64'd100, 64'd200, '0, '0, 1'b0);                  // idle beyond wall
    send_sample(3'd4, '1, '1, '1, '1, 1'b0);                            // all ones
    send_sample(3'd5, 64'h1_0000_0000, '0, '0, '0, 1'b0);               // wall delta wraps to 0
    send_sample(3'd6, 64'd1000, 64'h8000_0000, '0, 64'h8000_0000, 1'b0); // idle+nice wraps
    send_sample(3'd7, 64'hFFFF_FFFF, '0, '0, '0, 1'b1);                 // widest wall delta
    set_config(1'b1, 1'b0);
    send_sample(3'd1, 64'd3000, 64'd1100, 64'd200, 64'd9999, 1'b0);     // iowait busy, nice ignored
    send_sample(3'd2, 64'd1500, 64'd600, 64'd300, '0, 1'b1);            // iowait above idle
    set_config(1'b1, 1'b1);
    // long round of mostly full loads: sum and count saturate
    for (int k = 0; k < 16; k++) begin
      long_cpu = CPU_IDX_W'(k);
      send_sample(long_cpu, cum_wall[long_cpu] + 64'd1000, cum_idle[long_cpu],
                  cum_iowait[long_cpu], cum_nice[long_cpu], k == 15);
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(1'b0, 1'b1);
        1: set_config(1'b1, 1'b1);
        2: set_config(1'b0, 1'b0);
        3: set_config(1'b1, 1'b0);
        default: begin
          set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          gaps_on = 1'b0;
        end
      endcase
      for (int n = 0; n < 300; n++) begin
        if (phase == 1 && n == 100) rx_long_hold = 1'b1;
        if (phase == 2 && n == 150) drain();
        send_random();
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- cpu_load_percent_monitor.f -----
rtl/clpm_pkg.sv
rtl/clpm_hist.sv
rtl/clpm_div.sv
rtl/cpu_load_percent_monitor.sv
tb/cpu_load_percent_monitor_checker.sv
tb/cpu_load_percent_monitor_tb.sv
